[design/jsu_pkg.sv]
package jsu_pkg;

    // one input word: a text byte or the end of the text
    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } jsu_in_t;

    // one result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } jsu_out_t;

    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_CLOSE = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;

    // what one slot of a command emits
    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_CP    = 3'd1;
    localparam logic [2:0] K_RAW   = 3'd2;
    localparam logic [2:0] K_CLOSE = 3'd3;
    localparam logic [2:0] K_ERR   = 3'd4;

    localparam int CP_W = 21;

    typedef struct packed {
        logic [2:0]      kind;
        logic [CP_W-1:0] cp;
    } jsu_slot_t;

    // work for the back end: slot a first, then slot b
    typedef struct packed {
        jsu_slot_t a;
        jsu_slot_t b;
    } jsu_cmd_t;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
        if (cp < 21'h80) begin
            return 3'd1;
        end else if (cp < 21'h800) begin
            return 3'd2;
        end else if (cp < 21'h10000) begin
            return 3'd3;
        end else begin
            return 3'd4;
        end
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp, input logic [1:0] idx);
        logic [2:0] len;
        logic [7:0] r;
        len = utf8_len(cp);
        r = 8'h00;
        case (len)
            3'd1: r = cp[7:0];
            3'd2: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3: begin
                case (idx)
                    2'd0:    r = {4'b1110, cp[15:12]};
                    2'd1:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    r = {5'b11110, cp[20:18]};
                    2'd1:    r = {2'b10, cp[17:12]};
                    2'd2:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [2:0] slot_len(input jsu_slot_t s);
        case (s.kind)
            K_NONE:  return 3'd0;
            K_CP:    return utf8_len(s.cp);
            default: return 3'd1;
        endcase
    endfunction

endpackage

[design/jsu_front.sv]
module jsu_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  jsu_pkg::jsu_in_t in_word,
    output logic             cmd_push,
    output jsu_pkg::jsu_cmd_t cmd_data
);
    import jsu_pkg::*;

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_STR      = 4'd1;
    localparam logic [3:0] PH_ESC      = 4'd2;
    localparam logic [3:0] PH_HEX1     = 4'd3;
    localparam logic [3:0] PH_HEX1_B   = 4'd4;
    localparam logic [3:0] PH_HEX1_C   = 4'd5;
    localparam logic [3:0] PH_HEX1_D   = 4'd6;
    localparam logic [3:0] PH_HELD     = 4'd7;
    localparam logic [3:0] PH_HELD_ESC = 4'd8;
    localparam logic [3:0] PH_HEX2     = 4'd9;
    localparam logic [3:0] PH_HEX2_B   = 4'd10;
    localparam logic [3:0] PH_HEX2_C   = 4'd11;
    localparam logic [3:0] PH_HEX2_D   = 4'd12;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] hex_reg, hex_next;
    logic [15:0] held_reg, held_next;

    logic [7:0]  b;
    logic        fin;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] hex_new;
    logic        new_is_high, new_is_low;

    jsu_slot_t   str_slot, esc_slot, sa, sb, held_slot, fresh_slot;
    logic [3:0]  str_phase, esc_phase, fresh_phase;
    logic        esc_clr;

    assign b   = in_word.in_byte;
    assign fin = in_word.text_end;

    always_comb begin
        hex_ok  = 1'b0;
        hex_val = 4'd0;
        if (!fin) begin
            if (b inside {[8'h30:8'h39]}) begin
                hex_ok  = 1'b1;
                hex_val = b[3:0];
            end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
                hex_ok  = 1'b1;
                hex_val = 4'(b[3:0] + 4'd9);
            end
        end
    end

    assign hex_new     = {hex_reg[11:0], hex_val};
    assign new_is_high = hex_new inside {[16'hD800:16'hDBFF]};
    assign new_is_low  = hex_new inside {[16'hDC00:16'hDFFF]};
    assign held_slot   = '{kind: K_CP, cp: {5'd0, held_reg}};

    // plain string byte
    always_comb begin
        str_slot  = '{kind: K_NONE, cp: '0};
        str_phase = PH_STR;
        if (fin) begin
            str_slot.kind = K_ERR;
            str_phase     = PH_IDLE;
        end else if (b == CH_QUOTE) begin
            str_slot.kind = K_CLOSE;
            str_phase     = PH_IDLE;
        end else if (b == CH_BSL) begin
            str_phase = PH_ESC;
        end else begin
            str_slot = '{kind: K_RAW, cp: {13'd0, b}};
        end
    end

    // byte after a backslash
    always_comb begin
        esc_slot  = '{kind: K_RAW, cp: '0};
        esc_phase = PH_STR;
        esc_clr   = 1'b0;
        if (fin) begin
            esc_slot.kind = K_ERR;
            esc_phase     = PH_IDLE;
        end else begin
            case (b)
                8'h22:   esc_slot.cp = 21'h22;
                8'h5C:   esc_slot.cp = 21'h5C;
                8'h2F:   esc_slot.cp = 21'h2F;
                8'h62:   esc_slot.cp = 21'h08;
                8'h66:   esc_slot.cp = 21'h0C;
                8'h6E:   esc_slot.cp = 21'h0A;
                8'h72:   esc_slot.cp = 21'h0D;
                8'h74:   esc_slot.cp = 21'h09;
                CH_U: begin
                    esc_slot.kind = K_NONE;
                    esc_phase     = PH_HEX1;
                    esc_clr       = 1'b1;
                end
                default: begin
                    esc_slot.kind = K_ERR;
                    esc_phase     = PH_IDLE;
                end
            endcase
        end
    end

    // a completed four-digit value: held if a high surrogate, else emitted
    always_comb begin
        if (new_is_high) begin
            fresh_slot  = '{kind: K_NONE, cp: '0};
            fresh_phase = PH_HELD;
        end else begin
            fresh_slot  = '{kind: K_CP, cp: {5'd0, hex_new}};
            fresh_phase = PH_STR;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        hex_next   = hex_reg;
        held_next  = held_reg;
        sa         = '{kind: K_NONE, cp: '0};
        sb         = '{kind: K_NONE, cp: '0};
        case (phase_reg)
            PH_STR: begin
                sa         = str_slot;
                phase_next = str_phase;
            end
            PH_ESC: begin
                sa         = esc_slot;
                phase_next = esc_phase;
                if (esc_clr) begin
                    hex_next = '0;
                end
            end
            PH_HEX1, PH_HEX1_B, PH_HEX1_C, PH_HEX1_D: begin
                if (!hex_ok) begin
                    sa.kind    = K_ERR;
                    phase_next = PH_IDLE;
                end else begin
                    hex_next = hex_new;
                    if (phase_reg == PH_HEX1_D) begin
                        sa         = fresh_slot;
                        phase_next = fresh_phase;
                        if (new_is_high) begin
                            held_next = hex_new;
                        end
                    end else begin
                        phase_next = 4'(phase_reg + 4'd1);
                    end
                end
            end
            PH_HELD: begin
                if (!fin && b == CH_BSL) begin
                    phase_next = PH_HELD_ESC;
                end else begin
                    sa         = held_slot;
                    sb         = str_slot;
                    phase_next = str_phase;
                end
            end
            PH_HELD_ESC: begin
                if (!fin && b == CH_U) begin
                    hex_next   = '0;
                    phase_next = PH_HEX2;
                end else begin
                    sa         = held_slot;
                    sb         = esc_slot;
                    phase_next = esc_phase;
                    if (esc_clr) begin
                        hex_next = '0;
                    end
                end
            end
            PH_HEX2, PH_HEX2_B, PH_HEX2_C, PH_HEX2_D: begin
                if (!hex_ok) begin
                    sa         = held_slot;
                    sb.kind    = K_ERR;
                    phase_next = PH_IDLE;
                end else begin
                    hex_next = hex_new;
                    if (phase_reg != PH_HEX2_D) begin
                        phase_next = 4'(phase_reg + 4'd1);
                    end else if (new_is_low) begin
                        // surrogate pair: 0x10000 + ten bits of each half
                        sa.kind    = K_CP;
                        sa.cp      = 21'h10000 + {1'b0, held_reg[9:0], hex_new[9:0]};
                        phase_next = PH_STR;
                    end else begin
                        sa         = held_slot;
                        sb         = fresh_slot;
                        phase_next = fresh_phase;
                        if (new_is_high) begin
                            held_next = hex_new;
                        end
                    end
                end
            end
            default: begin
                // idle, and the unused codes behave as idle
                if (fin || b != CH_QUOTE) begin
                    sa.kind    = K_ERR;
                    phase_next = PH_IDLE;
                end else begin
                    phase_next = PH_STR;
                end
            end
        endcase
    end

    // keep any output in slot a
    always_comb begin
        if (sa.kind == K_NONE) begin
            cmd_data.a = sb;
            cmd_data.b = '{kind: K_NONE, cp: '0};
        end else begin
            cmd_data.a = sa;
            cmd_data.b = sb;
        end
    end

    assign cmd_push = in_fire && (cmd_data.a.kind != K_NONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            hex_reg   <= '0;
            held_reg  <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            hex_reg   <= hex_next;
            held_reg  <= held_next;
        end
    end

endmodule

[design/jsu_cmd_fifo.sv]
module jsu_cmd_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  jsu_pkg::jsu_cmd_t push_data,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output jsu_pkg::jsu_cmd_t head
);
    import jsu_pkg::*;

    jsu_cmd_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full       = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = (FIFO_AW+1)'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = (FIFO_AW+1)'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= FIFO_AW'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= FIFO_AW'(rd_ptr_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/jsu_back.sv]
module jsu_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  jsu_pkg::jsu_cmd_t head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output jsu_pkg::jsu_out_t m_data
);
    import jsu_pkg::*;

    logic       seg_reg, seg_next;
    logic [1:0] idx_reg, idx_next;
    logic       m_valid_reg;
    jsu_out_t   m_data_reg, word;

    jsu_slot_t  cur;
    logic [2:0] cur_len;
    logic       slot_done, cmd_done, load;

    assign cur       = seg_reg ? head.b : head.a;
    assign cur_len   = slot_len(cur);
    assign slot_done = ({1'b0, idx_reg} == 3'(cur_len - 3'd1));
    assign cmd_done  = slot_done && (seg_reg || head.b.kind == K_NONE);
    assign load      = head_valid && (!m_valid_reg || m_ready);
    assign pop       = load && cmd_done;

    always_comb begin
        word.last = cmd_done;
        case (cur.kind)
            K_CP: begin
                word.out_byte = utf8_byte(cur.cp, idx_reg);
                word.status   = ST_BYTE;
            end
            K_RAW: begin
                word.out_byte = cur.cp[7:0];
                word.status   = ST_BYTE;
            end
            K_CLOSE: begin
                word.out_byte = 8'h00;
                word.status   = ST_CLOSE;
            end
            default: begin
                word.out_byte = 8'h00;
                word.status   = ST_ERR;
            end
        endcase
    end

    // step through the bytes of slot a, then slot b
    always_comb begin
        seg_next = seg_reg;
        idx_next = idx_reg;
        if (load) begin
            if (cmd_done) begin
                seg_next = 1'b0;
                idx_next = 2'd0;
            end else if (slot_done) begin
                seg_next = 1'b1;
                idx_next = 2'd0;
            end else begin
                idx_next = 2'(idx_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg     <= 1'b0;
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            seg_reg <= seg_next;
            idx_reg <= idx_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[design/json_string_unescape_utf8.sv]
// channel  | dir | ports                       | word
// input    | in  | s_valid, s_ready, s_data    | in_byte, text_end
// result   | out | m_valid, m_ready, m_data    | out_byte, status, last
//
// one input word is taken per cycle while the four-entry command queue has room
// the back end sends result words in order: a word gives zero to six results
// first result passes through the command queue and the output register once its input word is taken
// aresetn (synchronous) returns the decoder to idle and empties the queue
// a stalled result channel fills the queue, then s_ready drops
module json_string_unescape_utf8 (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  jsu_pkg::jsu_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output jsu_pkg::jsu_out_t m_data
);
    import jsu_pkg::*;

    logic     in_fire, cmd_push, q_full, q_valid, q_pop;
    jsu_cmd_t cmd_data, q_head;

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    jsu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_word  (s_data),
        .cmd_push (cmd_push),
        .cmd_data (cmd_data)
    );

    jsu_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (cmd_push),
        .push_data  (cmd_data),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head)
    );

    jsu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

[sim/tb.sv]
module tb;
    import jsu_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_WORDS    = 76;

    // how a directed row is checked
    localparam int ROW_PREDICT = -1;
    localparam int ROW_SILENT  = 0;
    localparam int ROW_ONE     = 1;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    // decoder phases
    localparam logic [3:0] P_IDLE     = 4'd0;
    localparam logic [3:0] P_STR      = 4'd1;
    localparam logic [3:0] P_ESC      = 4'd2;
    localparam logic [3:0] P_HEX1     = 4'd3;
    localparam logic [3:0] P_HEX4     = 4'd6;
    localparam logic [3:0] P_HELD     = 4'd7;
    localparam logic [3:0] P_HELD_ESC = 4'd8;
    localparam logic [3:0] P_LOW1     = 4'd9;
    localparam logic [3:0] P_LOW4     = 4'd12;

    typedef struct {
        jsu_in_t  word;
        int       n_typed;
        jsu_out_t res;
    } dir_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    jsu_in_t  s_data  = '0;
    logic     m_ready = 1'b0;
    logic     s_ready;
    logic     m_valid;
    jsu_out_t m_data;

    json_string_unescape_utf8 uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // decoder state as the predictor sees it
    logic [3:0]  dec_phase = P_IDLE;
    logic [15:0] dec_accum = '0;
    logic [15:0] dec_high  = '0;
    jsu_out_t    word_out[$];
    jsu_out_t    pending_out[$];

    dir_row_t dir_tab[25];

    int n_words      = 0;
    int n_results    = 0;
    int n_closed     = 0;
    int n_errors     = 0;
    int n_fail       = 0;
    int idle_cycles  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_ask     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    function automatic void emit(input logic [7:0] b, input logic [1:0] st);
        jsu_out_t r;
        r.out_byte = b;
        r.status   = st;
        r.last     = 1'b0;
        word_out = {word_out, r};
    endfunction

    function automatic void emit_error();
        emit(8'h00, ST_ERR);
        dec_phase = P_IDLE;
    endfunction

    function automatic void emit_utf8(input int unsigned cp);
        if (cp < 32'h80) begin
            emit(8'(cp), ST_BYTE);
        end else if (cp < 32'h800) begin
            emit(8'(32'hC0 | (cp >> 6)), ST_BYTE);
            emit(8'(32'h80 | (cp & 32'h3F)), ST_BYTE);
        end else if (cp < 32'h10000) begin
            emit(8'(32'hE0 | (cp >> 12)), ST_BYTE);
            emit(8'(32'h80 | ((cp >> 6) & 32'h3F)), ST_BYTE);
            emit(8'(32'h80 | (cp & 32'h3F)), ST_BYTE);
        end else begin
            emit(8'(32'hF0 | (cp >> 18)), ST_BYTE);
            emit(8'(32'h80 | ((cp >> 12) & 32'h3F)), ST_BYTE);
            emit(8'(32'h80 | ((cp >> 6) & 32'h3F)), ST_BYTE);
            emit(8'(32'h80 | (cp & 32'h3F)), ST_BYTE);
        end
    endfunction

    function automatic int hex_val(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
        if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
        if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
        return -1;
    endfunction

    function automatic bit simple_escape(input logic [7:0] b, output logic [7:0] v);
        case (b)
            8'h22, 8'h5C, 8'h2F: v = b;
            8'h62: v = 8'h08;
            8'h66: v = 8'h0C;
            8'h6E: v = 8'h0A;
            8'h72: v = 8'h0D;
            8'h74: v = 8'h09;
            default: begin
                v = 8'h00;
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void string_byte(input logic [7:0] b, input logic e);
        if (e) begin
            emit_error();
        end else if (b == CH_QUOTE) begin
            emit(8'h00, ST_CLOSE);
            dec_phase = P_IDLE;
        end else if (b == CH_BSLASH) begin
            dec_phase = P_ESC;
        end else begin
            emit(b, ST_BYTE);
            dec_phase = P_STR;
        end
    endfunction

    function automatic void escape_byte(input logic [7:0] b, input logic e);
        logic [7:0] v;
        if (e) begin
            emit_error();
        end else if (b == CH_U) begin
            dec_accum = '0;
            dec_phase = P_HEX1;
        end else if (simple_escape(b, v)) begin
            emit(v, ST_BYTE);
            dec_phase = P_STR;
        end else begin
            emit_error();
        end
    endfunction

    // a high surrogate waits for a possible low, anything else goes out now
    function automatic void new_value(input logic [15:0] v);
        if (v >= 16'hD800 && v <= 16'hDBFF) begin
            dec_high  = v;
            dec_phase = P_HELD;
        end else begin
            emit_utf8(32'(v));
            dec_phase = P_STR;
        end
    endfunction

    function automatic void decode_word(input jsu_in_t w);
        logic [7:0] b;
        logic       e;
        int         d;
        b = w.in_byte;
        e = w.text_end;
        d = e ? -1 : hex_val(b);
        word_out.delete();
        if (dec_phase == P_STR) begin
            string_byte(b, e);
        end else if (dec_phase == P_ESC) begin
            escape_byte(b, e);
        end else if (dec_phase >= P_HEX1 && dec_phase <= P_HEX4) begin
            if (d < 0) begin
                emit_error();
            end else begin
                dec_accum = {dec_accum[11:0], 4'(d)};
                if (dec_phase == P_HEX4) new_value(dec_accum);
                else dec_phase++;
            end
        end else if (dec_phase == P_HELD) begin
            if (!e && b == CH_BSLASH) begin
                dec_phase = P_HELD_ESC;
            end else begin
                emit_utf8(32'(dec_high));
                string_byte(b, e);
            end
        end else if (dec_phase == P_HELD_ESC) begin
            if (!e && b == CH_U) begin
                dec_accum = '0;
                dec_phase = P_LOW1;
            end else begin
                emit_utf8(32'(dec_high));
                escape_byte(b, e);
            end
        end else if (dec_phase >= P_LOW1 && dec_phase <= P_LOW4) begin
            if (d < 0) begin
                emit_utf8(32'(dec_high));
                emit_error();
            end else begin
                dec_accum = {dec_accum[11:0], 4'(d)};
                if (dec_phase != P_LOW4) begin
                    dec_phase++;
                end else if (dec_accum >= 16'hDC00 && dec_accum <= 16'hDFFF) begin
                    emit_utf8(32'h10000 + ((32'(dec_high) - 32'hD800) << 10)
                              + (32'(dec_accum) - 32'hDC00));
                    dec_phase = P_STR;
                end else begin
                    emit_utf8(32'(dec_high));
                    new_value(dec_accum);
                end
            end
        end else begin
            // idle, and the unused codes behave the same
            if (e || b != CH_QUOTE) emit_error();
            else dec_phase = P_STR;
        end
        if (word_out.size() > 0) word_out[word_out.size() - 1].last = 1'b1;
    endfunction

    function automatic dir_row_t mk(input logic [7:0] b, input logic e, input int n,
                                    input logic [1:0] st, input logic [7:0] ob);
        dir_row_t r;
        r.word.in_byte  = b;
        r.word.text_end = e;
        r.n_typed       = n;
        r.res.out_byte  = ob;
        r.res.status    = st;
        r.res.last      = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        n_fail++;
    endtask

    task automatic offer(input jsu_in_t w, input int n_typed, input jsu_out_t typed_res);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        decode_word(w);
        // a typed row stands in for the predicted results
        if (n_typed != ROW_PREDICT) begin
            word_out.delete();
            if (n_typed == ROW_ONE) word_out = {typed_res};
        end
        pending_out = {pending_out, word_out};
        n_words++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        jsu_in_t w;
        w.in_byte  = b;
        w.text_end = 1'b0;
        offer(w, ROW_PREDICT, '0);
    endtask

    task automatic send_end();
        jsu_in_t w;
        w.in_byte  = 8'($urandom);
        w.text_end = 1'b1;
        offer(w, ROW_PREDICT, '0);
    endtask

    task automatic send_hex_digit(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) c = 8'h30 + 8'(nib);
        else c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
        send_byte(c);
    endtask

    task automatic send_u(input logic [15:0] v);
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        for (int i = 3; i >= 0; i--) send_hex_digit(v[4*i +: 4]);
    endtask

    task automatic send_simple_escape();
        send_byte(CH_BSLASH);
        case ($urandom_range(0, 7))
            0: send_byte(8'h22);
            1: send_byte(8'h5C);
            2: send_byte(8'h2F);
            3: send_byte(8'h62);
            4: send_byte(8'h66);
            5: send_byte(8'h6E);
            6: send_byte(8'h72);
            default: send_byte(8'h74);
        endcase
    endtask

    task automatic send_bad_escape();
        logic [7:0] b;
        logic [7:0] v;
        send_byte(CH_BSLASH);
        do b = 8'($urandom); while (simple_escape(b, v) || b == CH_U);
        send_byte(b);
    endtask

    task automatic send_bad_hex();
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) begin
            send_end();
        end else begin
            do b = 8'($urandom); while (hex_val(b) >= 0);
            send_byte(b);
        end
    endtask

    function automatic logic [15:0] rand_high();
        case ($urandom_range(0, 3))
            0: return 16'hD800;
            1: return 16'hDBFF;
            default: return 16'($urandom_range('hD800, 'hDBFF));
        endcase
    endfunction

    function automatic logic [15:0] rand_low();
        case ($urandom_range(0, 3))
            0: return 16'hDC00;
            1: return 16'hDFFF;
            default: return 16'($urandom_range('hDC00, 'hDFFF));
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    task automatic send_unicode();
        case ($urandom_range(0, 8))
            0: send_u(16'($urandom_range(0, 'h7F)));
            1: send_u(16'($urandom_range('h80, 'h7FF)));
            2: begin
                if ($urandom_range(0, 1)) send_u(16'($urandom_range('h800, 'hD7FF)));
                else send_u(16'($urandom_range('hE000, 'hFFFF)));
            end
            3: begin
                send_u(rand_high());
                send_u(rand_low());
            end
            4: send_u(rand_high());
            5: send_u(rand_low());
            6: begin
                send_u(rand_high());
                send_u(16'($urandom_range(0, 'hD7FF)));
            end
            7: begin
                send_u(rand_high());
                send_u(rand_high());
                send_u(rand_low());
            end
            default: begin
                send_u(rand_high());
                send_simple_escape();
            end
        endcase
    endtask

    // malformed tails, each leaves the decoder idle
    task automatic send_fault();
        case ($urandom_range(0, 5))
            0: send_bad_escape();
            1: begin
                send_byte(CH_BSLASH);
                send_byte(CH_U);
                repeat ($urandom_range(0, 3)) send_hex_digit(4'($urandom));
                send_bad_hex();
            end
            2: begin
                send_u(rand_high());
                send_byte(CH_BSLASH);
                send_byte(CH_U);
                repeat ($urandom_range(0, 3)) send_hex_digit(4'($urandom));
                send_bad_hex();
            end
            3: send_end();
            4: begin
                send_byte(CH_BSLASH);
                send_end();
            end
            default: begin
                send_u(rand_high());
                case ($urandom_range(0, 2))
                    0: send_end();
                    1: send_bad_escape();
                    default: begin
                        send_byte(CH_BSLASH);
                        send_end();
                    end
                endcase
            end
        endcase
    endtask

    task automatic send_string();
        int n_seg;
        int k;
        send_byte(CH_QUOTE);
        n_seg = $urandom_range(1, 6);
        for (int i = 0; i < n_seg; i++) begin
            k = $urandom_range(0, 15);
            if (k <= 4) begin
                send_byte(plain_byte());
            end else if (k <= 6) begin
                send_simple_escape();
            end else if (k <= 14) begin
                send_unicode();
            end else begin
                send_fault();
                return;
            end
        end
        if ($urandom_range(0, 19) == 0) send_end();
        else send_byte(CH_QUOTE);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    jsu_out_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (m_data.status == ST_CLOSE) n_closed++;
            if (m_data.status == ST_ERR) n_errors++;
            if (pending_out.size() == 0) begin
                report_mismatch($sformatf("result word %0d not expected: %h", n_results, m_data));
            end else begin
                want = pending_out.pop_front();
                if (m_data.out_byte !== want.out_byte)
                    report_mismatch($sformatf("result word %0d: out_byte %h, want %h",
                                              n_results, m_data.out_byte, want.out_byte));
                if (m_data.status !== want.status)
                    report_mismatch($sformatf("result word %0d: status %0d, want %0d",
                                              n_results, m_data.status, want.status));
                if (m_data.last !== want.last)
                    report_mismatch($sformatf("result word %0d: last %b, want %b",
                                              n_results, m_data.last, want.last));
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_out.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int target;
        int phase_start;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        dir_tab = '{
            mk(8'h00,     1'b1, ROW_ONE,     ST_ERR,   8'h00),  // end of text while idle
            mk(8'hFF,     1'b0, ROW_ONE,     ST_ERR,   8'h00),  // no opening quote
            mk(CH_QUOTE,  1'b0, ROW_SILENT,  ST_BYTE,  8'h00),
            mk(8'h00,     1'b0, ROW_ONE,     ST_BYTE,  8'h00),
            mk(8'hFF,     1'b0, ROW_ONE,     ST_BYTE,  8'hFF),
            mk(CH_BSLASH, 1'b0, ROW_SILENT,  ST_BYTE,  8'h00),
            mk(8'h6E,     1'b0, ROW_ONE,     ST_BYTE,  8'h0A),
            mk(CH_BSLASH, 1'b0, ROW_SILENT,  ST_BYTE,  8'h00),  // highest high surrogate
            mk(CH_U,      1'b0, ROW_SILENT,  ST_BYTE,  8'h00),
            mk(8'h44,     1'b0, ROW_SILENT,  ST_BYTE,  8'h00),
            mk(8'h62,     1'b0, ROW_SILENT,  ST_BYTE,  8'h00),
            mk(8'h46,     1'b0, ROW_SILENT,  ST_BYTE,  8'h00),
            mk(8'h66,     1'b0, ROW_SILENT,  ST_BYTE,  8'h00),
            mk(CH_BSLASH, 1'b0, ROW_SILENT,  ST_BYTE,  8'h00),  // lowest low surrogate
            mk(CH_U,      1'b0, ROW_SILENT,  ST_BYTE,  8'h00),
            mk(8'h64,     1'b0, ROW_SILENT,  ST_BYTE,  8'h00),
            mk(8'h43,     1'b0, ROW_SILENT,  ST_BYTE,  8'h00),
            mk(8'h30,     1'b0, ROW_SILENT,  ST_BYTE,  8'h00),
            mk(8'h30,     1'b0, ROW_PREDICT, ST_BYTE,  8'h00),
            mk(CH_QUOTE,  1'b0, ROW_ONE,     ST_CLOSE, 8'h00),
            mk(CH_QUOTE,  1'b0, ROW_SILENT,  ST_BYTE,  8'h00),
            mk(CH_BSLASH, 1'b0, ROW_SILENT,  ST_BYTE,  8'h00),
            mk(8'h71,     1'b0, ROW_ONE,     ST_ERR,   8'h00),  // unknown escape
            mk(CH_QUOTE,  1'b0, ROW_SILENT,  ST_BYTE,  8'h00),
            mk(8'h5A,     1'b1, ROW_ONE,     ST_ERR,   8'h00)   // text ends in a string
        };
        foreach (dir_tab[i]) offer(dir_tab[i].word, dir_tab[i].n_typed, dir_tab[i].res);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 52; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
                default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
            endcase
            phase_start = n_words;
            target = n_words + PHASE_WORDS;
            while (n_words < target) begin
                // long result hold-off while words keep coming
                if (p == 0 && hold_ask == 0 && n_words - phase_start > 15) hold_ask = 1;
                if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 1)) send_end();
                    else send_byte(plain_byte());
                end
                send_string();
            end
        end
        s_valid <= 1'b0;

        while (pending_out.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("run covered %0d input words and %0d result words (%0d strings closed, %0d errors)",
                 n_words, n_results, n_closed, n_errors);
        $display("directed table, then four idle and stall mixes with one long result hold-off");
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
